### rtl/core/sm83_pkg.sv
package sm83_pkg;

    localparam int MEM_DEPTH = 65536;

    // flag register bit positions
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    // action codes of an input word
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_EXEC = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_INC,
        ALU_XOR,
        ALU_CP,
        ALU_RL,
        ALU_BIT,
        ALU_RES,
        ALU_SET
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] bidx;
        logic [7:0] flags;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flags;
    } t_alu_rsp;

endpackage

### rtl/core/sm83_alu.sv
module sm83_alu (
    input  sm83_pkg::t_alu_req i_req,
    output sm83_pkg::t_alu_rsp o_rsp
);

    logic [7:0] w_sum;
    logic [7:0] w_diff;
    logic [7:0] w_mask;
    logic [7:0] w_res;
    logic [7:0] w_f;

    assign w_sum  = i_req.a + 8'd1;
    assign w_diff = i_req.a - i_req.b;
    assign w_mask = 8'd1 << i_req.bidx;

    // compute result and new flags for the selected operation
    always_comb begin
        w_res = i_req.a;
        w_f   = i_req.flags;
        unique case (i_req.op)
            sm83_pkg::ALU_PASS: begin
                w_res = i_req.b;
            end
            sm83_pkg::ALU_INC: begin
                w_res = w_sum;
                w_f[sm83_pkg::FLAG_Z] = (w_sum == 8'd0);
                w_f[sm83_pkg::FLAG_N] = 1'b0;
                w_f[sm83_pkg::FLAG_H] = (i_req.a[3:0] == 4'hF);
            end
            sm83_pkg::ALU_XOR: begin
                w_res = i_req.a ^ i_req.b;
                w_f   = 8'd0;
                w_f[sm83_pkg::FLAG_Z] = ((i_req.a ^ i_req.b) == 8'd0);
            end
            sm83_pkg::ALU_CP: begin
                w_f[sm83_pkg::FLAG_Z] = (w_diff == 8'd0);
                w_f[sm83_pkg::FLAG_N] = 1'b1;
                w_f[sm83_pkg::FLAG_H] = (i_req.a[3:0] < i_req.b[3:0]);
                w_f[sm83_pkg::FLAG_C] = (i_req.a < i_req.b);
            end
            sm83_pkg::ALU_RL: begin
                w_res = {i_req.a[6:0], i_req.flags[sm83_pkg::FLAG_C]};
                w_f[sm83_pkg::FLAG_Z] = ({i_req.a[6:0], i_req.flags[sm83_pkg::FLAG_C]} == 8'd0);
                w_f[sm83_pkg::FLAG_N] = 1'b0;
                w_f[sm83_pkg::FLAG_H] = 1'b0;
                w_f[sm83_pkg::FLAG_C] = i_req.a[7];
            end
            sm83_pkg::ALU_BIT: begin
                w_f[sm83_pkg::FLAG_Z] = ((i_req.a & w_mask) == 8'd0);
                w_f[sm83_pkg::FLAG_N] = 1'b0;
                w_f[sm83_pkg::FLAG_H] = 1'b1;
            end
            sm83_pkg::ALU_RES: begin
                w_res = i_req.a & ~w_mask;
            end
            sm83_pkg::ALU_SET: begin
                w_res = i_req.a | w_mask;
            end
            default: begin
                w_res = i_req.a;
            end
        endcase
    end

    assign o_rsp.res   = w_res;
    assign o_rsp.flags = w_f;

endmodule

### rtl/core/sm83_partial_instruction_core.sv
// Subset SM83 core with a private 64K byte memory. Each input word loads a
// memory byte, peeks one, or executes one instruction at PC; every word
// returns one result word with the register file, PC, SP, the instruction's
// nominal cycle count and the peeked byte. A load goes through S_OUT, a peek
// through S_PEEK and S_OUT, an instruction through S_OP, S_B1, S_B2, S_WB,
// S_PUSH for PUSH and CALL, and S_OUT; a result that waits for i_ready holds
// the core in S_OUT, and no word is taken before it returns to S_IDLE. The
// sequencer reads opcode, two following bytes and one operand through the
// single memory read port, one access a clock, then retires through one shared ALU.
// An unimplemented opcode halts the core with state unchanged; later
// execute words report a cycle count of zero.
module sm83_partial_instruction_core #(
    parameter int MEM_DEPTH = sm83_pkg::MEM_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_acc,
    output logic [7:0]  o_flags,
    output logic [7:0]  o_reg_b,
    output logic [7:0]  o_reg_c,
    output logic [7:0]  o_reg_d,
    output logic [7:0]  o_reg_e,
    output logic [7:0]  o_reg_h,
    output logic [7:0]  o_reg_l,
    output logic [15:0] o_prog_counter,
    output logic [15:0] o_stack_pointer,
    output logic [4:0]  o_cycle_count,
    output logic [7:0]  o_read_data
);

    localparam int AW = $clog2(MEM_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PEEK = 4'd1;
    localparam logic [3:0] S_OP   = 4'd2;
    localparam logic [3:0] S_B1   = 4'd3;
    localparam logic [3:0] S_B2   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_PUSH = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam logic [2:0] R_B = 3'd0;
    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_D = 3'd2;
    localparam logic [2:0] R_E = 3'd3;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;
    localparam logic [2:0] R_M = 3'd6;
    localparam logic [2:0] R_A = 3'd7;

    localparam logic [1:0] P_BC = 2'd0;
    localparam logic [1:0] P_DE = 2'd1;
    localparam logic [1:0] P_HL = 2'd2;
    localparam logic [1:0] P_SP = 2'd3;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] r_mem_q;

    logic [3:0]  r_state;
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [15:0] r_pc, r_sp;
    logic        r_halt;
    logic [7:0]  r_op, r_b1, r_b2, r_push_lo;
    logic [4:0]  r_cyc;
    logic [7:0]  r_rd;

    logic        w_acc;
    logic        w_mwe;
    logic [15:0] w_mwa;
    logic [7:0]  w_mwd;
    logic [15:0] w_mra;
    logic [15:0] w_hl;

    // decode results
    logic        d_impl;
    logic [4:0]  d_cyc;
    logic [15:0] d_pc;
    logic        d_rw_en;
    logic [2:0]  d_rw_sel;
    logic        d_f_en;
    logic        d_mw_en;
    logic [15:0] d_mw_addr;
    logic        d_mw_alu;
    logic [7:0]  d_mw_val;
    logic        d_pw_en;
    logic [1:0]  d_pw_sel;
    logic [15:0] d_pw_val;
    logic        d_push;
    logic [7:0]  d_push_lo;

    sm83_pkg::t_alu_req w_alu_req;
    sm83_pkg::t_alu_rsp w_alu_rsp;

    sm83_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_acc = i_valid && o_ready;
    assign w_hl  = {r_h, r_l};

    function automatic logic [7:0] opnd(
        input logic [2:0] code,
        input logic [7:0] b, c, d, e, h, l, m, a
    );
        logic [7:0] v;
        unique case (code)
            R_B:     v = b;
            R_C:     v = c;
            R_D:     v = d;
            R_E:     v = e;
            R_H:     v = h;
            R_L:     v = l;
            R_M:     v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    // pick the memory read address from the state and, for the operand, from the opcode
    always_comb begin
        unique case (r_state)
            S_IDLE: w_mra = (i_action == sm83_pkg::ACT_EXEC) ? r_pc : i_address;
            S_OP:   w_mra = r_pc + 16'd1;
            S_B1:   w_mra = r_pc + 16'd2;
            S_B2: begin
                if (r_op == 8'h0A)      w_mra = {r_b, r_c};
                else if (r_op == 8'h1A) w_mra = {r_d, r_e};
                else if (r_op == 8'hF0) w_mra = {8'hFF, r_b1};
                else                    w_mra = w_hl;
            end
            default: w_mra = r_pc;
        endcase
    end

    // decode the instruction held in r_op, r_b1, r_b2 and the operand byte
    always_comb begin
        logic [2:0]  src, dst, cr, cb;
        logic [1:0]  cg;
        logic [7:0]  vsrc, vdst, vcr;
        logic [15:0] pc1, pc2, pc3;
        src  = r_op[2:0];
        dst  = r_op[5:3];
        cr   = r_b1[2:0];
        cb   = r_b1[5:3];
        cg   = r_b1[7:6];
        vsrc = opnd(src, r_b, r_c, r_d, r_e, r_h, r_l, r_mem_q, r_a);
        vdst = opnd(dst, r_b, r_c, r_d, r_e, r_h, r_l, r_mem_q, r_a);
        vcr  = opnd(cr, r_b, r_c, r_d, r_e, r_h, r_l, r_mem_q, r_a);
        pc1  = r_pc + 16'd1;
        pc2  = r_pc + 16'd2;
        pc3  = r_pc + 16'd3;

        d_impl    = 1'b1;
        d_cyc     = 5'd4;
        d_pc      = pc1;
        d_rw_en   = 1'b0;
        d_rw_sel  = R_A;
        d_f_en    = 1'b0;
        d_mw_en   = 1'b0;
        d_mw_addr = w_hl;
        d_mw_alu  = 1'b0;
        d_mw_val  = r_a;
        d_pw_en   = 1'b0;
        d_pw_sel  = P_HL;
        d_pw_val  = 16'd0;
        d_push    = 1'b0;
        d_push_lo = 8'd0;
        w_alu_req.op    = sm83_pkg::ALU_PASS;
        w_alu_req.a     = r_a;
        w_alu_req.b     = vsrc;
        w_alu_req.bidx  = cb;
        w_alu_req.flags = r_f;

        priority if (r_op[7:6] == 2'b01 && r_op != 8'h76) begin
            // LD r,r' and LD (HL),r; LD r,(HL) is unimplemented
            if (src == R_M) begin
                d_impl = 1'b0;
            end else if (dst == R_M) begin
                d_mw_en  = 1'b1;
                d_mw_alu = 1'b1;
                d_cyc    = 5'd8;
            end else begin
                d_rw_en  = 1'b1;
                d_rw_sel = dst;
            end
        end else if (r_op[7:3] == 5'b10101 && r_op != 8'hAE) begin
            w_alu_req.op = sm83_pkg::ALU_XOR;
            d_rw_en      = 1'b1;
            d_f_en       = 1'b1;
        end else begin
            unique case (r_op)
                8'h00: begin
                    d_cyc = 5'd4;
                end
                8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24, 8'h2C, 8'h3C: begin
                    w_alu_req.op = sm83_pkg::ALU_INC;
                    w_alu_req.a  = vdst;
                    d_rw_en      = 1'b1;
                    d_rw_sel     = dst;
                    d_f_en       = 1'b1;
                end
                8'h20, 8'h30: begin
                    if (!(r_op[4] ? r_f[sm83_pkg::FLAG_C] : r_f[sm83_pkg::FLAG_Z])) begin
                        d_pc  = pc2 + {{8{r_b1[7]}}, r_b1};
                        d_cyc = 5'd12;
                    end else begin
                        d_pc  = pc2;
                        d_cyc = 5'd8;
                    end
                end
                8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E: begin
                    w_alu_req.b = r_b1;
                    d_rw_en     = 1'b1;
                    d_rw_sel    = dst;
                    d_pc        = pc2;
                    d_cyc       = 5'd8;
                end
                8'h0A, 8'h1A: begin
                    w_alu_req.b = r_mem_q;
                    d_rw_en     = 1'b1;
                    d_cyc       = 5'd8;
                end
                8'h36: begin
                    d_mw_en  = 1'b1;
                    d_mw_val = r_b1;
                    d_pc     = pc2;
                    d_cyc    = 5'd12;
                end
                8'h01, 8'h11, 8'h21, 8'h31: begin
                    d_pw_en  = 1'b1;
                    d_pw_sel = r_op[5:4];
                    d_pw_val = {r_b2, r_b1};
                    d_pc     = pc3;
                    d_cyc    = 5'd12;
                end
                8'h22, 8'h32, 8'h2A, 8'h3A: begin
                    if (r_op[3]) begin
                        w_alu_req.b = r_mem_q;
                        d_rw_en     = 1'b1;
                    end else begin
                        d_mw_en = 1'b1;
                    end
                    d_pw_en  = 1'b1;
                    d_pw_val = r_op[4] ? (w_hl - 16'd1) : (w_hl + 16'd1);
                    d_cyc    = 5'd8;
                end
                8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
                    d_push    = 1'b1;
                    d_mw_en   = 1'b1;
                    d_mw_addr = r_sp - 16'd1;
                    unique case (r_op[5:4])
                        2'd0:    begin d_mw_val = r_b; d_push_lo = r_c; end
                        2'd1:    begin d_mw_val = r_d; d_push_lo = r_e; end
                        2'd2:    begin d_mw_val = r_h; d_push_lo = r_l; end
                        default: begin d_mw_val = r_a; d_push_lo = r_f; end
                    endcase
                    d_cyc = 5'd16;
                end
                8'hCD: begin
                    d_push    = 1'b1;
                    d_mw_en   = 1'b1;
                    d_mw_addr = r_sp - 16'd1;
                    d_mw_val  = pc3[15:8];
                    d_push_lo = pc3[7:0];
                    d_pc      = {r_b2, r_b1};
                    d_cyc     = 5'd24;
                end
                8'hF0: begin
                    w_alu_req.b = r_mem_q;
                    d_rw_en     = 1'b1;
                    d_pc        = pc2;
                    d_cyc       = 5'd12;
                end
                8'hE0: begin
                    d_mw_en   = 1'b1;
                    d_mw_addr = {8'hFF, r_b1};
                    d_pc      = pc2;
                    d_cyc     = 5'd12;
                end
                8'hE2: begin
                    d_mw_en   = 1'b1;
                    d_mw_addr = {8'hFF, r_c};
                    d_cyc     = 5'd8;
                end
                8'hFE: begin
                    w_alu_req.op = sm83_pkg::ALU_CP;
                    w_alu_req.b  = r_b1;
                    d_f_en       = 1'b1;
                    d_pc         = pc2;
                    d_cyc        = 5'd8;
                end
                8'hCB: begin
                    w_alu_req.a = vcr;
                    d_pc        = pc2;
                    d_cyc       = (cr == R_M) ? 5'd16 : 5'd8;
                    d_f_en      = 1'b1;
                    unique case (cg)
                        2'd0:    w_alu_req.op = sm83_pkg::ALU_RL;
                        2'd1:    w_alu_req.op = sm83_pkg::ALU_BIT;
                        2'd2:    w_alu_req.op = sm83_pkg::ALU_RES;
                        default: w_alu_req.op = sm83_pkg::ALU_SET;
                    endcase
                    if (cg == 2'd0 && cb != 3'd2) begin
                        d_impl = 1'b0;
                    end else if (cg == 2'd1) begin
                        d_cyc = (cr == R_M) ? 5'd12 : 5'd8;
                    end else if (cr == R_M) begin
                        d_mw_en  = 1'b1;
                        d_mw_alu = 1'b1;
                    end else begin
                        d_rw_en  = 1'b1;
                        d_rw_sel = cr;
                    end
                end
                default: begin
                    d_impl = 1'b0;
                end
            endcase
        end
    end

    // steer the single memory write port
    always_comb begin
        w_mwe = 1'b0;
        w_mwa = i_address;
        w_mwd = i_data;
        unique case (r_state)
            S_IDLE: w_mwe = w_acc && (i_action == sm83_pkg::ACT_LOAD);
            S_WB: begin
                w_mwe = d_impl && d_mw_en;
                w_mwa = d_mw_addr;
                w_mwd = d_mw_alu ? w_alu_rsp.res : d_mw_val;
            end
            S_PUSH: begin
                w_mwe = 1'b1;
                w_mwa = r_sp - 16'd2;
                w_mwd = r_push_lo;
            end
            default: w_mwe = 1'b0;
        endcase
    end

    // memory array with registered read
    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            mem[w_mwa[AW-1:0]] <= w_mwd;
        end
        r_mem_q <= mem[w_mra[AW-1:0]];
    end

    // sequence one word: a load, a peek, or an instruction's fetch, operand read and retire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a     <= 8'd0;
            r_f     <= 8'd0;
            r_b     <= 8'd0;
            r_c     <= 8'd0;
            r_d     <= 8'd0;
            r_e     <= 8'd0;
            r_h     <= 8'd0;
            r_l     <= 8'd0;
            r_pc    <= 16'd0;
            r_sp    <= 16'd0;
            r_halt  <= 1'b0;
            r_cyc   <= 5'd0;
            r_rd    <= 8'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cyc <= 5'd0;
                        r_rd  <= 8'd0;
                        if (i_action == sm83_pkg::ACT_PEEK) begin
                            r_state <= S_PEEK;
                        end else if (i_action == sm83_pkg::ACT_EXEC && !r_halt) begin
                            r_state <= S_OP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_PEEK: begin
                    r_rd    <= r_mem_q;
                    r_state <= S_OUT;
                end
                S_OP: begin
                    r_op    <= r_mem_q;
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_b1    <= r_mem_q;
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_b2    <= r_mem_q;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (d_impl && d_push) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_OUT;
                    end
                    if (!d_impl) begin
                        r_halt <= 1'b1;
                    end else begin
                        r_cyc <= d_cyc;
                        r_pc  <= d_pc;
                        if (d_f_en) begin
                            r_f <= w_alu_rsp.flags;
                        end
                        if (d_rw_en) begin
                            unique case (d_rw_sel)
                                R_B:     r_b <= w_alu_rsp.res;
                                R_C:     r_c <= w_alu_rsp.res;
                                R_D:     r_d <= w_alu_rsp.res;
                                R_E:     r_e <= w_alu_rsp.res;
                                R_H:     r_h <= w_alu_rsp.res;
                                R_L:     r_l <= w_alu_rsp.res;
                                default: r_a <= w_alu_rsp.res;
                            endcase
                        end
                        if (d_pw_en) begin
                            unique case (d_pw_sel)
                                P_BC: {r_b, r_c} <= d_pw_val;
                                P_DE: {r_d, r_e} <= d_pw_val;
                                P_HL: {r_h, r_l} <= d_pw_val;
                                P_SP: r_sp <= d_pw_val;
                            endcase
                        end
                        if (d_push) begin
                            r_push_lo <= d_push_lo;
                        end
                    end
                end
                S_PUSH: begin
                    r_sp    <= r_sp - 16'd2;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_acc           = r_a;
    assign o_flags         = r_f;
    assign o_reg_b         = r_b;
    assign o_reg_c         = r_c;
    assign o_reg_d         = r_d;
    assign o_reg_e         = r_e;
    assign o_reg_h         = r_h;
    assign o_reg_l         = r_l;
    assign o_prog_counter  = r_pc;
    assign o_stack_pointer = r_sp;
    assign o_cycle_count   = r_cyc;
    assign o_read_data     = r_rd;

endmodule
